@@ sv/gtl_pkg.sv @@
// Shared types, widths and register codes for the grid triangle locator.
// No dependencies; every other file of the block imports this package.
package gtl_pkg;

  // Fixed-point formats.
  localparam int POS_W           = 32;
  localparam int POS_FRAC_BITS   = 16;
  localparam int SCALE_W         = 32;
  localparam int SCALE_FRAC_BITS = 24;
  localparam int PROD_FRAC_BITS  = POS_FRAC_BITS + SCALE_FRAC_BITS;
  localparam int PROD_W          = POS_W + SCALE_W;

  // Grid limits.
  localparam int MAX_TILES_PER_SIDE = 256;
  localparam int MAX_VERTS_PER_EDGE = 1024;
  localparam int MPS_W    = 9;
  localparam int VPE_W    = 11;
  localparam int EM1_W    = $clog2(MAX_VERTS_PER_EDGE);
  localparam int HALF_W   = PROD_FRAC_BITS - 1 + MPS_W;
  localparam int U_W      = HALF_W + 1;
  localparam int IDX_W    = U_W - PROD_FRAC_BITS;
  localparam int SCALED_W = EM1_W + PROD_FRAC_BITS;
  localparam int SUB_W    = SCALED_W - PROD_FRAC_BITS;

  // Result field widths.
  localparam int TILE_ID_W = 17;
  localparam int VTX_W     = 20;

  // Pipeline depth: four stages per coordinate lane, two for the combine.
  localparam int STAGES = 6;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MESH_SCALE      = 2'd0,
    REG_MESHES_PER_SIDE = 2'd1,
    REG_VERTS_PER_EDGE  = 2'd2
  } cfg_reg_e;

  typedef logic [STAGES-1:0] stage_vec_t;

  // Configuration as seen by the datapath (already saturated).
  typedef struct packed {
    logic [SCALE_W-1:0] mesh_scale;
    logic [MPS_W-1:0]   mps;
    logic [VPE_W-1:0]   vpe;
    logic [EM1_W-1:0]   em1;
  } cfg_t;

  // What one coordinate lane hands to the combine stages.
  typedef struct packed {
    logic                      ok;
    logic [IDX_W-1:0]          idx;
    logic [SUB_W-1:0]          sub;
    logic [PROD_FRAC_BITS-1:0] rem;
  } lane_out_t;

endpackage

@@ sv/gtl_cfg_regs.sv @@
// Configuration registers of the grid triangle locator, saturated on write.
// Depends on gtl_pkg.
module gtl_cfg_regs
  import gtl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  logic [SCALE_W-1:0] scale_q;
  logic [MPS_W-1:0]   mps_q, mps_sat;
  logic [VPE_W-1:0]   vpe_q, vpe_sat;
  logic [EM1_W-1:0]   em1_q;
  logic [MPS_W-1:0]   mps_raw;
  logic [VPE_W-1:0]   vpe_raw;

  // Writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Clamp the tile count and the edge vertex count into their legal ranges.
  always_comb begin
    mps_raw = cfg_data_i[MPS_W-1:0];
    vpe_raw = cfg_data_i[VPE_W-1:0];
    if (mps_raw == '0) begin
      mps_sat = MPS_W'(1);
    end else if (mps_raw > MPS_W'(MAX_TILES_PER_SIDE)) begin
      mps_sat = MPS_W'(MAX_TILES_PER_SIDE);
    end else begin
      mps_sat = mps_raw;
    end
    if (vpe_raw < VPE_W'(2)) begin
      vpe_sat = VPE_W'(2);
    end else if (vpe_raw > VPE_W'(MAX_VERTS_PER_EDGE)) begin
      vpe_sat = VPE_W'(MAX_VERTS_PER_EDGE);
    end else begin
      vpe_sat = vpe_raw;
    end
  end

  // Register file; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_W'(1) << SCALE_FRAC_BITS;
      mps_q   <= MPS_W'(16);
      vpe_q   <= VPE_W'(65);
      em1_q   <= EM1_W'(64);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MESH_SCALE: begin
          scale_q <= cfg_data_i[SCALE_W-1:0];
        end
        REG_MESHES_PER_SIDE: begin
          mps_q <= mps_sat;
        end
        REG_VERTS_PER_EDGE: begin
          vpe_q <= vpe_sat;
          em1_q <= EM1_W'(vpe_sat - VPE_W'(1));
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o.mesh_scale = scale_q;
  assign cfg_o.mps        = mps_q;
  assign cfg_o.vpe        = vpe_q;
  assign cfg_o.em1        = em1_q;

endmodule

@@ sv/gtl_coord_lane.sv @@
// One coordinate lane: magnitude, scale multiply, bound check and shift,
// then the split into tile index, row or column, and remainder. Uses gtl_pkg.
module gtl_coord_lane
  import gtl_pkg::*;
(
  input  logic             clk_i,
  input  stage_vec_t       en_i,
  input  cfg_t             cfg_i,
  input  logic [POS_W-1:0] pos_i,
  output lane_out_t        lane_o
);

  logic                      neg1_q, neg2_q;
  logic [POS_W-1:0]          mag1_q;
  logic [PROD_W-1:0]         t2_q, t2_d;
  logic                      ok3_q, ok3_d, ok4_q;
  logic [U_W-1:0]            u3_q, u3_d;
  logic [HALF_W-1:0]         half;
  logic [SCALED_W-1:0]       sx4_q, sx4_d;
  logic [IDX_W-1:0]          idx4_q;

  // Half the tile count in product format.
  assign half = {cfg_i.mps, (PROD_FRAC_BITS - 1)'(0)};

  // Stage 1: sign and magnitude (the most negative input gives 2^31).
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      neg1_q <= pos_i[POS_W-1];
      mag1_q <= pos_i[POS_W-1] ? (~pos_i + POS_W'(1)) : pos_i;
    end
  end

  // Stage 2: magnitude times the reciprocal tile span.
  assign t2_d = PROD_W'(mag1_q) * PROD_W'(cfg_i.mesh_scale);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      neg2_q <= neg1_q;
      t2_q   <= t2_d;
    end
  end

  // Stage 3: bound test, equality accepted, and shift by half the grid.
  always_comb begin
    ok3_d = (t2_q <= PROD_W'(half));
    if (neg2_q) begin
      u3_d = U_W'(half) - U_W'(t2_q);
    end else begin
      u3_d = U_W'(half) + U_W'(t2_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      ok3_q <= ok3_d;
      u3_q  <= u3_d;
    end
  end

  // Stage 4: scale the in-tile fraction by the quad count per edge.
  assign sx4_d = SCALED_W'(cfg_i.em1) * SCALED_W'(u3_q[PROD_FRAC_BITS-1:0]);

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      ok4_q  <= ok3_q;
      idx4_q <= u3_q[U_W-1:PROD_FRAC_BITS];
      sx4_q  <= sx4_d;
    end
  end

  assign lane_o.ok  = ok4_q;
  assign lane_o.idx = idx4_q;
  assign lane_o.sub = sx4_q[SCALED_W-1:PROD_FRAC_BITS];
  assign lane_o.rem = sx4_q[PROD_FRAC_BITS-1:0];

endmodule

@@ sv/gtl_tri_select.sv @@
// Combine stages: tile number, base vertex and triangle choice, then the
// output word with the three vertex indexes. Uses gtl_pkg.
module gtl_tri_select
  import gtl_pkg::*;
(
  input  logic                 clk_i,
  input  stage_vec_t           en_i,
  input  cfg_t                 cfg_i,
  input  lane_out_t            x_i,
  input  lane_out_t            z_i,
  output logic                 in_range_o,
  output logic [TILE_ID_W-1:0] tile_id_o,
  output logic                 upper_o,
  output logic [VTX_W-1:0]     first_o,
  output logic [VTX_W-1:0]     second_o,
  output logic [VTX_W-1:0]     third_o
);

  localparam int SUM_W = PROD_FRAC_BITS + 1;

  logic                 ok5_q;
  logic                 up5_q, up5_d;
  logic [TILE_ID_W-1:0] tile5_q, tile5_d;
  logic [VTX_W-1:0]     e5_q, e5_d;
  logic [SUM_W-1:0]     rsum;
  logic [VTX_W-1:0]     vpe_w;

  logic                 ok6_q, up6_q;
  logic [TILE_ID_W-1:0] tile6_q;
  logic [VTX_W-1:0]     v0_q, v1_q, v2_q;
  logic [VTX_W-1:0]     v0_d, v1_d, v2_d;

  // Stage 5: tile number, base vertex, and which half of the quad.
  always_comb begin
    tile5_d = TILE_ID_W'(x_i.idx) + TILE_ID_W'(cfg_i.mps) * TILE_ID_W'(z_i.idx);
    e5_d    = VTX_W'(x_i.sub) + VTX_W'(z_i.sub) * VTX_W'(cfg_i.vpe);
    rsum    = SUM_W'(x_i.rem) + SUM_W'(z_i.rem);
    up5_d   = rsum > (SUM_W'(1) << PROD_FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      ok5_q   <= x_i.ok & z_i.ok;
      tile5_q <= tile5_d;
      e5_q    <= e5_d;
      up5_q   <= up5_d;
    end
  end

  // Stage 6: vertex indexes; everything reads zero outside the grid.
  assign vpe_w = VTX_W'(cfg_i.vpe);

  always_comb begin
    if (up5_q) begin
      v0_d = e5_q + VTX_W'(1);
      v1_d = e5_q + vpe_w;
      v2_d = e5_q + vpe_w + VTX_W'(1);
    end else begin
      v0_d = e5_q;
      v1_d = e5_q + VTX_W'(1);
      v2_d = e5_q + vpe_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      ok6_q   <= ok5_q;
      up6_q   <= ok5_q & up5_q;
      tile6_q <= ok5_q ? tile5_q : '0;
      v0_q    <= ok5_q ? v0_d : '0;
      v1_q    <= ok5_q ? v1_d : '0;
      v2_q    <= ok5_q ? v2_d : '0;
    end
  end

  assign in_range_o = ok6_q;
  assign tile_id_o  = tile6_q;
  assign upper_o    = up6_q;
  assign first_o    = v0_q;
  assign second_o   = v1_q;
  assign third_o    = v2_q;

endmodule

@@ sv/grid_triangle_locator.sv @@
// Top level of the grid triangle locator: handshake and valid pipeline.
// Depends on gtl_pkg, gtl_cfg_regs, gtl_coord_lane and gtl_tri_select.
//
//   channel | direction | handshake               | word
//   --------+-----------+-------------------------+-------------------------------
//   cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//   in      | in        | in_valid_i/in_ready_o   | pos_x_i, pos_z_i
//   out     | out       | out_valid_o/out_ready_i | in_range_o .. third_vertex_o
//
// One word enters per cycle while in_ready_o is high. The edge that takes a word loads it
// into the first of six register stages (sign, 32x32 multiply, bound and shift, fraction
// multiply, combine, output register), and its result is shown from the last of them.
// Reset clears the valid bits and loads the register defaults.
// A stage holds only while the stage after it is full and held, so bubbles
// close up under a stalled output and nothing is dropped or repeated.
module grid_triangle_locator
  import gtl_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [POS_W-1:0]     pos_x_i,
  input  logic signed [POS_W-1:0]     pos_z_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        in_range_o,
  output logic [TILE_ID_W-1:0]        tile_id_o,
  output logic                        upper_triangle_o,
  output logic [VTX_W-1:0]            first_vertex_o,
  output logic [VTX_W-1:0]            second_vertex_o,
  output logic [VTX_W-1:0]            third_vertex_o
);

  cfg_t       cfg;
  stage_vec_t valid_q, valid_d, en;
  lane_out_t  lane_x, lane_z;

  gtl_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Stage enables: a stage loads when it is empty or its successor moves.
  always_comb begin
    en[STAGES-1] = ~valid_q[STAGES-1] | out_ready_i;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = ~valid_q[k] | en[k+1];
    end
  end

  // Valid bits travel with the data.
  always_comb begin
    valid_d = valid_q;
    if (en[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < STAGES; k++) begin
      if (en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[STAGES-1];

  // Coordinate lanes: x gives the row, z the column.
  gtl_coord_lane u_lane_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .cfg_i  (cfg),
    .pos_i  (pos_x_i),
    .lane_o (lane_x)
  );

  gtl_coord_lane u_lane_z (
    .clk_i  (clk_i),
    .en_i   (en),
    .cfg_i  (cfg),
    .pos_i  (pos_z_i),
    .lane_o (lane_z)
  );

  gtl_tri_select u_tri (
    .clk_i      (clk_i),
    .en_i       (en),
    .cfg_i      (cfg),
    .x_i        (lane_x),
    .z_i        (lane_z),
    .in_range_o (in_range_o),
    .tile_id_o  (tile_id_o),
    .upper_o    (upper_triangle_o),
    .first_o    (first_vertex_o),
    .second_o   (second_vertex_o),
    .third_o    (third_vertex_o)
  );

endmodule

@@ sv/gtl_checker.sv @@
// Port-level checks for the grid triangle locator, bound to the top level.
// Depends on gtl_pkg and grid_triangle_locator.
module gtl_checker
  import gtl_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic                    in_range_o,
  input logic [TILE_ID_W-1:0]    tile_id_o,
  input logic                    upper_triangle_o,
  input logic [VTX_W-1:0]        first_vertex_o,
  input logic [VTX_W-1:0]        second_vertex_o,
  input logic [VTX_W-1:0]        third_vertex_o
);

  // A result word stays put until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(first_vertex_o)
      && $stable(tile_id_o) && $stable(in_range_o))
    else $error("result word changed while stalled");

  // A reset leaves the result side empty by the next edge.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid after reset");

  // A ready output side never blocks the input side.
  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output is ready");

  // Outside the grid every other field reads zero.
  a_out_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_range_o |-> tile_id_o == '0 && !upper_triangle_o
      && first_vertex_o == '0 && second_vertex_o == '0 && third_vertex_o == '0)
    else $error("nonzero fields outside the grid");

  // Neighboring vertices of a triangle differ by one in the right pair.
  a_vtx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_range_o |->
      (upper_triangle_o && third_vertex_o == second_vertex_o + VTX_W'(1))
      || (!upper_triangle_o && second_vertex_o == first_vertex_o + VTX_W'(1)))
    else $error("vertex indexes not adjacent");

endmodule

bind grid_triangle_locator gtl_checker u_gtl_checker (.*);

@@ verif/gtl_locate_checker.sv @@
// Checker for the grid triangle locator: watches the config, input and result channels.
// It predicts each result from its own copy of the registers and compares it field by field.
// Depends on gtl_pkg for widths, limits and register codes.
module gtl_locate_checker
  import gtl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [POS_W-1:0]      pos_x_i,
  input  logic [POS_W-1:0]      pos_z_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic                  in_range_i,
  input  logic [TILE_ID_W-1:0]  tile_id_i,
  input  logic                  upper_triangle_i,
  input  logic [VTX_W-1:0]      first_vertex_i,
  input  logic [VTX_W-1:0]      second_vertex_i,
  input  logic [VTX_W-1:0]      third_vertex_i,
  output int unsigned           mismatches_o,
  output int unsigned           pending_o
);

  localparam logic [SCALE_W-1:0] RESET_SCALE = 32'h0100_0000;
  localparam logic [MPS_W-1:0]   RESET_MPS   = 9'd16;
  localparam logic [VPE_W-1:0]   RESET_VPE   = 11'd65;
  localparam logic [63:0]        FRAC_MASK   = (64'd1 << PROD_FRAC_BITS) - 64'd1;
  localparam logic [63:0]        UNIT_Q      = 64'd1 << PROD_FRAC_BITS;
  localparam int                 REPORT_MAX  = 10;

  typedef struct packed {
    logic                 in_range;
    logic [TILE_ID_W-1:0] tile_id;
    logic                 upper_triangle;
    logic [VTX_W-1:0]     first_vertex;
    logic [VTX_W-1:0]     second_vertex;
    logic [VTX_W-1:0]     third_vertex;
  } loc_result_t;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_z;
    loc_result_t      want;
  } loc_expect_t;

  // Register copies as written, before saturation.
  logic [SCALE_W-1:0] scale_q;
  logic [MPS_W-1:0]   mps_q;
  logic [VPE_W-1:0]   vpe_q;

  loc_expect_t expected_tris[$];
  loc_expect_t head;
  loc_expect_t incoming;
  loc_result_t got;

  // Scales one coordinate and shifts it by the half grid. Bit 64 is set when it lies inside.
  function automatic logic [64:0] scale_axis(input logic [POS_W-1:0] pos,
                                             input logic [63:0] half);
    logic [63:0] mag;
    logic [63:0] prod;
    mag  = pos[POS_W-1] ? (64'h1_0000_0000 - {32'd0, pos}) : {32'd0, pos};
    prod = mag * {32'd0, scale_q};
    if (prod > half) return {1'b0, 64'd0};
    return {1'b1, pos[POS_W-1] ? half - prod : half + prod};
  endfunction

  // Full lookup of one position: tile, triangle half and its three vertex indices.
  function automatic loc_result_t locate_triangle(input logic [POS_W-1:0] x,
                                                  input logic [POS_W-1:0] z);
    logic [63:0] mps, vpe, half, ux, uz, sx, sz, base, tile, va, vb, vc;
    logic [64:0] ax, az;
    loc_result_t r;
    mps  = (mps_q == 0) ? 64'd1 :
           (mps_q > MAX_TILES_PER_SIDE) ? 64'(MAX_TILES_PER_SIDE) : 64'(mps_q);
    vpe  = (vpe_q < 2) ? 64'd2 :
           (vpe_q > MAX_VERTS_PER_EDGE) ? 64'(MAX_VERTS_PER_EDGE) : 64'(vpe_q);
    half = mps << (PROD_FRAC_BITS - 1);
    r    = '0;
    ax   = scale_axis(x, half);
    az   = scale_axis(z, half);
    if (!ax[64] || !az[64]) return r;
    ux   = ax[63:0];
    uz   = az[63:0];
    sx   = (vpe - 64'd1) * (ux & FRAC_MASK);
    sz   = (vpe - 64'd1) * (uz & FRAC_MASK);
    // Row comes from x, column from z; the column strides by the edge count.
    base = (sx >> PROD_FRAC_BITS) + (sz >> PROD_FRAC_BITS) * vpe;
    tile = (ux >> PROD_FRAC_BITS) + mps * (uz >> PROD_FRAC_BITS);
    r.in_range       = 1'b1;
    r.tile_id        = tile[TILE_ID_W-1:0];
    r.upper_triangle = ((sx & FRAC_MASK) + (sz & FRAC_MASK)) > UNIT_Q;
    if (r.upper_triangle) begin
      va = base + 64'd1;
      vb = base + vpe;
      vc = base + vpe + 64'd1;
    end else begin
      va = base;
      vb = base + 64'd1;
      vc = base + vpe;
    end
    r.first_vertex  = va[VTX_W-1:0];
    r.second_vertex = vb[VTX_W-1:0];
    r.third_vertex  = vc[VTX_W-1:0];
    return r;
  endfunction

  // Results are checked before new words are queued; a word never leaves in its own cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q = RESET_SCALE;
      mps_q   = RESET_MPS;
      vpe_q   = RESET_VPE;
      expected_tris.delete();
      mismatches_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = {in_range_i, tile_id_i, upper_triangle_i,
               first_vertex_i, second_vertex_i, third_vertex_i};
        if (expected_tris.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= REPORT_MAX)
            $display("[%0t] unexpected result: in=%0d tile=%0d up=%0d v=%0d/%0d/%0d",
                     $realtime, got.in_range, got.tile_id, got.upper_triangle,
                     got.first_vertex, got.second_vertex, got.third_vertex);
        end else begin
          head = expected_tris.pop_front();
          if (got.in_range       != head.want.in_range       ||
              got.tile_id        != head.want.tile_id        ||
              got.upper_triangle != head.want.upper_triangle ||
              got.first_vertex   != head.want.first_vertex   ||
              got.second_vertex  != head.want.second_vertex  ||
              got.third_vertex   != head.want.third_vertex) begin
            mismatches_o++;
            if (mismatches_o <= REPORT_MAX) begin
              $write("[%0t] mismatch x=%h z=%h: expected in=%0d tile=%0d up=%0d v=%0d/%0d/%0d",
                     $realtime, head.pos_x, head.pos_z,
                     head.want.in_range, head.want.tile_id, head.want.upper_triangle,
                     head.want.first_vertex, head.want.second_vertex,
                     head.want.third_vertex);
              $display(", got in=%0d tile=%0d up=%0d v=%0d/%0d/%0d",
                       got.in_range, got.tile_id, got.upper_triangle,
                       got.first_vertex, got.second_vertex, got.third_vertex);
            end
          end
        end
      end
      // Register writes; an index past the last register leaves everything alone.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MESH_SCALE:      scale_q = cfg_data_i[SCALE_W-1:0];
          REG_MESHES_PER_SIDE: mps_q   = cfg_data_i[MPS_W-1:0];
          REG_VERTS_PER_EDGE:  vpe_q   = cfg_data_i[VPE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        incoming.pos_x = pos_x_i;
        incoming.pos_z = pos_z_i;
        incoming.want  = locate_triangle(pos_x_i, pos_z_i);
        expected_tris.insert(expected_tris.size(), incoming);
      end
      pending_o = expected_tris.size();
    end
  end

endmodule

@@ verif/tb_grid_triangle_locator.sv @@
// Testbench top for the grid triangle locator: clock, reset, stimulus and verdict.
// Position words stream under random bursts and output stalls across several grid settings.
// Depends on gtl_pkg, grid_triangle_locator and gtl_locate_checker.
module tb_grid_triangle_locator;
  import gtl_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_IDX = 2'd3;
  localparam int                   QUIET_LIMIT    = 4000;

  typedef enum int {SINK_FREE, SINK_LIGHT, SINK_HEAVY, SINK_PERIODIC} sink_mode_e;

  logic                        clk_i;
  logic                        rst_ni       = 1'b0;
  logic                        cfg_valid_i  = 1'b0;
  logic                        cfg_ready_o;
  logic [CFG_IDX_W-1:0]        cfg_index_i  = REG_MESH_SCALE;
  logic [CFG_DATA_W-1:0]       cfg_data_i   = '0;
  logic                        in_valid_i   = 1'b0;
  logic                        in_ready_o;
  logic signed [POS_W-1:0]     pos_x_i      = '0;
  logic signed [POS_W-1:0]     pos_z_i      = '0;
  logic                        out_valid_o;
  logic                        out_ready_i  = 1'b0;
  logic                        in_range_o;
  logic [TILE_ID_W-1:0]        tile_id_o;
  logic                        upper_triangle_o;
  logic [VTX_W-1:0]            first_vertex_o;
  logic [VTX_W-1:0]            second_vertex_o;
  logic [VTX_W-1:0]            third_vertex_o;

  int unsigned mismatches;
  int unsigned words_in_flight;

  // Grid setting as the block sees it, used only to aim positions at the bound.
  logic [SCALE_W-1:0] grid_scale = 32'h0100_0000;
  logic [MPS_W-1:0]   grid_mps   = 9'd16;

  bit          gaps_on;
  int unsigned burst_left;
  sink_mode_e  sink_mode;
  int unsigned mode_left;
  int unsigned quiet_cycles;

  grid_triangle_locator DUT (.*);

  gtl_locate_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .pos_x_i          (pos_x_i),
    .pos_z_i          (pos_z_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .in_range_i       (in_range_o),
    .tile_id_i        (tile_id_o),
    .upper_triangle_i (upper_triangle_o),
    .first_vertex_i   (first_vertex_o),
    .second_vertex_i  (second_vertex_o),
    .third_vertex_i   (third_vertex_o),
    .mismatches_o     (mismatches),
    .pending_o        (words_in_flight)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The result side switches at random between stall patterns.
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(50, 300);
    end
    mode_left--;
    case (sink_mode)
      SINK_FREE:  out_ready_i <= 1'b1;
      SINK_LIGHT: out_ready_i <= ($urandom_range(0, 3) != 0);
      SINK_HEAVY: out_ready_i <= ($urandom_range(0, 3) == 0);
      default:    out_ready_i <= ((mode_left % 8) < 3);
    endcase
  end

  // Watchdog: too long without any word moving on any channel ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One position word; valid stays high into the next word unless a gap starts.
  task automatic send_pos(input logic [POS_W-1:0] x, input logic [POS_W-1:0] z);
    if (gaps_on && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    in_valid_i <= 1'b1;
    pos_x_i    <= x;
    pos_z_i    <= z;
    do @(posedge clk_i); while (!in_ready_o);
    if (burst_left > 0) burst_left--;
  endtask

  // Stops sending and waits until every result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (words_in_flight != 0);
    @(posedge clk_i);
  endtask

  // Leaves cfg valid high so back-to-back writes never drop it within a step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_grid(input logic [31:0] scale, input logic [31:0] mps_data,
                          input logic [31:0] vpe_data);
    wait_drained();
    write_reg(REG_MESH_SCALE, scale);
    write_reg(REG_MESHES_PER_SIDE, mps_data);
    write_reg(REG_VERTS_PER_EDGE, vpe_data);
    cfg_valid_i <= 1'b0;
    grid_scale = scale;
    grid_mps   = (mps_data[MPS_W-1:0] == 0) ? 9'd1 :
                 (mps_data[MPS_W-1:0] > MAX_TILES_PER_SIDE) ? 9'(MAX_TILES_PER_SIDE) :
                 mps_data[MPS_W-1:0];
  endtask

  // Mostly positions inside the grid, some right at its bound, some anywhere.
  function automatic logic [POS_W-1:0] rand_coord();
    logic [63:0] lim;
    logic [63:0] mag;
    int unsigned sel;
    lim = (grid_scale == 0) ? 64'h8000_0000 :
          (64'(grid_mps) << (PROD_FRAC_BITS - 1)) / 64'(grid_scale);
    if (lim > 64'h8000_0000) lim = 64'h8000_0000;
    sel = $urandom_range(0, 99);
    if (sel >= 85) return $urandom;
    if (sel >= 70) begin
      mag = lim + 64'($urandom_range(0, 2));
      if (mag != 0) mag = mag - 64'd1;
    end else begin
      mag = {$urandom, $urandom} % (lim + 64'd1);
    end
    if (mag > 64'h8000_0000) mag = 64'h8000_0000;
    if ($urandom_range(0, 1)) return 32'd0 - mag[31:0];
    return (mag == 64'h8000_0000) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

  task automatic run_random(input int n);
    gaps_on    = ($urandom_range(0, 3) != 0);
    burst_left = 0;
    repeat (n) send_pos(rand_coord(), rand_coord());
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset grid: span 1.0, 16 tiles, 65 vertices; the bound sits at +/-8.0.
    gaps_on = 1'b1;
    send_pos(32'h0000_0000, 32'h0000_0000);
    send_pos(32'h0008_0000, 32'h0008_0000);   // exactly on the bound, one past the last tile
    send_pos(32'hFFF8_0000, 32'hFFF8_0000);   // exactly on the negative bound
    send_pos(32'h0008_0001, 32'h0000_0000);   // x just outside
    send_pos(32'h0000_0000, 32'hFFF7_FFFF);   // z just outside
    send_pos(32'h7FFF_FFFF, 32'h8000_0000);
    send_pos(32'h8000_0000, 32'h0000_0000);
    send_pos(32'h0000_0000, 32'h7FFF_FFFF);
    send_pos(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pos(32'h0000_0001, 32'h0000_0001);
    send_pos(32'h0000_0200, 32'h0000_0200);   // remainders sum to exactly one: lower
    send_pos(32'h0000_0200, 32'h0000_0201);   // just above one: upper
    send_pos(32'h0007_FFFF, 32'h0007_FFFF);
    send_pos(32'h0005_5555, 32'hFFFA_AAAB);
    send_pos(32'h5555_5555, 32'hAAAA_AAAA);
    run_random(60);

    // A write past the last register must change nothing.
    wait_drained();
    write_reg(REG_UNUSED_IDX, 32'hFFFF_FFFF);
    cfg_valid_i <= 1'b0;
    run_random(40);

    // Largest span reciprocal, most tiles, longest edge.
    set_grid(32'hFFFF_FFFF, 32'd256, 32'd1024);
    run_random(70);
    // Zero scale; tile and edge counts below their floors saturate up.
    set_grid(32'h0000_0000, 32'd0, 32'd0);
    run_random(60);
    // The tile count above its ceiling saturates down, the edge count below its floor up.
    set_grid(32'h0001_0000, 32'd300, 32'd1);
    run_random(60);
    // Upper data bits are dropped before saturation.
    set_grid(32'h8000_0000, 32'hFFFF_FE01, 32'hFFFF_F7FF);
    run_random(60);

    repeat (4) begin
      set_grid($urandom >> $urandom_range(0, 16), $urandom_range(1, 256),
               $urandom_range(2, 1024));
      run_random(50);
    end

    wait_drained();
    repeat (STAGES + 4) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatches == 0 && words_in_flight == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
